FILE: src/cpt_pkg.sv
// ---------------------------------------------------------------------------
// cpt_pkg
// shared constants, region codes and latency helpers for the closest point
// on triangle pipeline
// ---------------------------------------------------------------------------
package cpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    // limb width of the pipelined multipliers
    localparam int LIMB = 32;

    // register stages through cpt_mul
    localparam int MUL_LAT = 5;

    typedef enum logic [2:0] {
        REG_A  = 3'd0,
        REG_B  = 3'd1,
        REG_AB = 3'd2,
        REG_C  = 3'd3,
        REG_AC = 3'd4,
        REG_BC = 3'd5,
        REG_IN = 3'd6
    } t_region;

    // register stages through cpt_div for a given coordinate width
    function automatic int div_lat(input int cw);
        return cw + 6;
    endfunction

endpackage

FILE: src/cpt_delay.sv
// ---------------------------------------------------------------------------
// cpt_delay
// fixed-length shift register that carries side data alongside a pipeline
// ---------------------------------------------------------------------------
module cpt_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        r_sr[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_sr[k] <= r_sr[k-1];
        end
    end

    assign o_q = r_sr[DEPTH-1];

endmodule

FILE: src/cpt_mul.sv
// ---------------------------------------------------------------------------
// cpt_mul
// pipelined signed multiplier, sign and magnitude, built from limb products
// ---------------------------------------------------------------------------
module cpt_mul import cpt_pkg::*; #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                    i_clk,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);

    localparam int NA = (WA + LIMB - 1) / LIMB;
    localparam int NB = (WB + LIMB - 1) / LIMB;
    localparam int AW = NA * LIMB;
    localparam int BW = NB * LIMB;
    localparam int RW = AW + LIMB;
    localparam int TW = AW + BW;
    localparam int PW = WA + WB;

    logic [WA-1:0]       w_am;
    logic [WB-1:0]       w_bm;
    logic [AW-1:0]       r_am;
    logic [BW-1:0]       r_bm;
    logic [2*LIMB-1:0]   r_pp [NA][NB];
    logic [RW-1:0]       w_row [NB];
    logic [RW-1:0]       r_row [NB];
    logic [TW-1:0]       w_tot;
    logic [PW-1:0]       r_mag;
    logic                r_s0, r_s1, r_s2, r_s3;

    assign w_am = i_a[WA-1] ? WA'(-i_a) : WA'(i_a);
    assign w_bm = i_b[WB-1] ? WB'(-i_b) : WB'(i_b);

    always_comb begin
        for (int j = 0; j < NB; j++) begin
            w_row[j] = '0;
            for (int i = 0; i < NA; i++) begin
                w_row[j] = w_row[j] + (RW'(r_pp[i][j]) << (i * LIMB));
            end
        end
    end

    always_comb begin
        w_tot = '0;
        for (int j = 0; j < NB; j++) begin
            w_tot = w_tot + (TW'(r_row[j]) << (j * LIMB));
        end
    end

    always_ff @(posedge i_clk) begin
        r_am <= AW'(w_am);
        r_bm <= BW'(w_bm);
        r_s0 <= i_a[WA-1] ^ i_b[WB-1];
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i][j] <= r_am[i*LIMB +: LIMB] * r_bm[j*LIMB +: LIMB];
            end
        end
        r_s1  <= r_s0;
        r_row <= w_row;
        r_s2  <= r_s1;
        r_mag <= PW'(w_tot);
        r_s3  <= r_s2;
        o_p   <= r_s3 ? -r_mag : r_mag;
    end

endmodule

FILE: src/cpt_div.sv
// ---------------------------------------------------------------------------
// cpt_div
// pipelined restoring divider, one quotient bit per stage, truncating toward
// zero, then adds the base coordinate and saturates
// ---------------------------------------------------------------------------
module cpt_div import cpt_pkg::*; #(
    parameter int NUMW = 171,
    parameter int DENW = 139,
    parameter int CW   = 32
) (
    input  logic                   i_clk,
    input  logic signed [NUMW-1:0] i_num,
    input  logic signed [DENW-1:0] i_den,
    input  logic signed [CW-1:0]   i_base,
    output logic signed [CW-1:0]   o_res
);

    // a quotient wider than this always saturates once added to the base
    localparam int QW = CW + 2;
    localparam int RW = (NUMW > DENW + QW) ? NUMW : DENW + QW;
    localparam int SW = CW + 3;
    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    logic [NUMW-1:0]        w_nm;
    logic [DENW-1:0]        w_dm;
    logic [RW-1:0]          r0_n, r0_d;
    logic                   r0_neg;
    logic signed [CW-1:0]   r0_base;

    logic [RW-1:0]          r_rem [QW+1];
    logic [RW-1:0]          r_dv  [QW+1];
    logic [QW-1:0]          r_q   [QW+1];
    logic                   r_ng  [QW+1];
    logic                   r_ov  [QW+1];
    logic signed [CW-1:0]   r_bs  [QW+1];

    logic signed [SW-1:0]   r_qs;
    logic                   r_ovf, r_ngf;
    logic signed [CW-1:0]   r_bsf;
    logic signed [SW-1:0]   w_sum;

    assign w_nm = i_num[NUMW-1] ? NUMW'(-i_num) : NUMW'(i_num);
    assign w_dm = i_den[DENW-1] ? DENW'(-i_den) : DENW'(i_den);

    always_ff @(posedge i_clk) begin
        r0_n    <= RW'(w_nm);
        r0_d    <= RW'(w_dm);
        r0_neg  <= i_num[NUMW-1] ^ i_den[DENW-1];
        r0_base <= i_base;

        r_rem[0] <= r0_n;
        r_dv[0]  <= r0_d;
        r_q[0]   <= '0;
        r_ng[0]  <= r0_neg;
        r_ov[0]  <= r0_n >= (r0_d << QW);
        r_bs[0]  <= r0_base;
    end

    for (genvar s = 0; s < QW; s++) begin : g_step
        localparam int SH = QW - 1 - s;
        logic [RW-1:0] w_sd;
        logic          w_ge;

        assign w_sd = r_dv[s] << SH;
        assign w_ge = r_rem[s] >= w_sd;

        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= w_ge ? r_rem[s] - w_sd : r_rem[s];
            r_dv[s+1]  <= r_dv[s];
            r_q[s+1]   <= {r_q[s][QW-2:0], w_ge};
            r_ng[s+1]  <= r_ng[s];
            r_ov[s+1]  <= r_ov[s];
            r_bs[s+1]  <= r_bs[s];
        end
    end

    assign w_sum = SW'(r_bsf) + r_qs;

    always_ff @(posedge i_clk) begin
        r_qs  <= r_ng[QW] ? -SW'(r_q[QW]) : SW'(r_q[QW]);
        r_ovf <= r_ov[QW];
        r_ngf <= r_ng[QW];
        r_bsf <= r_bs[QW];

        if (r_ovf) begin
            o_res <= r_ngf ? MINV : MAXV;
        end else if (w_sum > SW'(MAXV)) begin
            o_res <= MAXV;
        end else if (w_sum < SW'(MINV)) begin
            o_res <= MINV;
        end else begin
            o_res <= CW'(w_sum);
        end
    end

endmodule

FILE: src/closest_point_on_triangle.sv
// ---------------------------------------------------------------------------
// closest_point_on_triangle
// closest point of a triangle to a query point, Voronoi region test,
// exact full-width products, truncating division
// ---------------------------------------------------------------------------
// Takes one item in every cycle: busy stays low and an item is accepted
// whenever start is high. Each item gives one result, strobed by o_valid
// for one cycle. The delay from acceptance to result is set by three limb
// multipliers in series (five stages each) and by the restoring divider,
// which takes one quotient bit per stage over COORD_WIDTH + 2 stages. The
// pipeline never stalls, so results must be taken as they appear.
module closest_point_on_triangle import cpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_a_z,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_b_z,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_c_z,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_closest_x,
    output logic signed [COORD_WIDTH-1:0] o_closest_y,
    output logic signed [COORD_WIDTH-1:0] o_closest_z,
    output t_region                       o_region
);

    localparam int CW      = COORD_WIDTH;
    localparam int DW      = CW + 1;
    localparam int PW      = 2 * DW;
    localparam int DOTW    = PW + 2;
    localparam int EW      = DOTW + 1;
    localparam int VW      = 2 * DOTW + 1;
    localparam int XW      = VW;
    localparam int NUMW    = XW + DW + 1;
    localparam int DENW    = VW + 2;
    localparam int DL      = div_lat(CW);
    localparam int OUT_LAT = 3 * MUL_LAT + 7 + DL;
    localparam int GW      = 3 * 3 * CW + 3 * 3 * DW;
    localparam int SW9     = 6 * DOTW + 4 * EW;
    localparam int TLW     = DENW + 3 * CW + 3;

    logic [OUT_LAT-1:0] r_vld;
    logic               w_acc;

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[OUT_LAT-2:0], w_acc};
        end
    end

    assign o_valid = r_vld[OUT_LAT-1];

    // stage 1: input registers
    logic signed [CW-1:0] r1_p [3];
    logic signed [CW-1:0] r1_a [3];
    logic signed [CW-1:0] r1_b [3];
    logic signed [CW-1:0] r1_c [3];

    always_ff @(posedge i_clk) begin
        r1_p[0] <= i_point_x;    r1_p[1] <= i_point_y;    r1_p[2] <= i_point_z;
        r1_a[0] <= i_vertex_a_x; r1_a[1] <= i_vertex_a_y; r1_a[2] <= i_vertex_a_z;
        r1_b[0] <= i_vertex_b_x; r1_b[1] <= i_vertex_b_y; r1_b[2] <= i_vertex_b_z;
        r1_c[0] <= i_vertex_c_x; r1_c[1] <= i_vertex_c_y; r1_c[2] <= i_vertex_c_z;
    end

    // stage 2: edge and offset vectors
    logic [2:0][DW-1:0] r2_ab, r2_ac, r2_ap, r2_bp, r2_cp, r2_cb;
    logic [2:0][CW-1:0] r2_a, r2_b, r2_c;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r2_ab[k] <= DW'(r1_b[k]) - DW'(r1_a[k]);
            r2_ac[k] <= DW'(r1_c[k]) - DW'(r1_a[k]);
            r2_ap[k] <= DW'(r1_p[k]) - DW'(r1_a[k]);
            r2_bp[k] <= DW'(r1_p[k]) - DW'(r1_b[k]);
            r2_cp[k] <= DW'(r1_p[k]) - DW'(r1_c[k]);
            r2_cb[k] <= DW'(r1_c[k]) - DW'(r1_b[k]);
            r2_a[k]  <= r1_a[k];
            r2_b[k]  <= r1_b[k];
            r2_c[k]  <= r1_c[k];
        end
    end

    // dot product terms: d1 ab.ap, d2 ac.ap, d3 ab.bp, d4 ac.bp, d5 ab.cp, d6 ac.cp
    logic [DW-1:0]        w_dl [6][3];
    logic [DW-1:0]        w_dr [6][3];
    logic signed [PW-1:0] w_pr [6][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dl[0][k] = r2_ab[k]; w_dr[0][k] = r2_ap[k];
            w_dl[1][k] = r2_ac[k]; w_dr[1][k] = r2_ap[k];
            w_dl[2][k] = r2_ab[k]; w_dr[2][k] = r2_bp[k];
            w_dl[3][k] = r2_ac[k]; w_dr[3][k] = r2_bp[k];
            w_dl[4][k] = r2_ab[k]; w_dr[4][k] = r2_cp[k];
            w_dl[5][k] = r2_ac[k]; w_dr[5][k] = r2_cp[k];
        end
    end

    for (genvar j = 0; j < 6; j++) begin : g_dot
        for (genvar k = 0; k < 3; k++) begin : g_cmp
            cpt_mul #(.WA(DW), .WB(DW)) u_mul (
                .i_clk (i_clk),
                .i_a   (w_dl[j][k]),
                .i_b   (w_dr[j][k]),
                .o_p   (w_pr[j][k])
            );
        end
    end

    // stage 8: dot products
    logic [5:0][DOTW-1:0] r8_d;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 6; j++) begin
            r8_d[j] <= DOTW'(w_pr[j][0]) + DOTW'(w_pr[j][1]) + DOTW'(w_pr[j][2]);
        end
    end

    // barycentric cross terms
    logic signed [2*DOTW-1:0] w_vp [6];
    logic [DOTW-1:0]          w_va [6];
    logic [DOTW-1:0]          w_vbo [6];

    assign w_va[0] = r8_d[0]; assign w_vbo[0] = r8_d[3];
    assign w_va[1] = r8_d[2]; assign w_vbo[1] = r8_d[1];
    assign w_va[2] = r8_d[4]; assign w_vbo[2] = r8_d[1];
    assign w_va[3] = r8_d[0]; assign w_vbo[3] = r8_d[5];
    assign w_va[4] = r8_d[2]; assign w_vbo[4] = r8_d[5];
    assign w_va[5] = r8_d[4]; assign w_vbo[5] = r8_d[3];

    for (genvar j = 0; j < 6; j++) begin : g_vm
        cpt_mul #(.WA(DOTW), .WB(DOTW)) u_mul (
            .i_clk (i_clk),
            .i_a   (w_va[j]),
            .i_b   (w_vbo[j]),
            .o_p   (w_vp[j])
        );
    end

    // stage 9: differences of dot products
    logic [5:0][DOTW-1:0] r9_d;
    logic signed [EW-1:0] r9_e1, r9_e2, r9_dab, r9_dac;

    always_ff @(posedge i_clk) begin
        r9_d   <= r8_d;
        r9_e1  <= EW'($signed(r8_d[3])) - EW'($signed(r8_d[2]));
        r9_e2  <= EW'($signed(r8_d[4])) - EW'($signed(r8_d[5]));
        r9_dab <= EW'($signed(r8_d[0])) - EW'($signed(r8_d[2]));
        r9_dac <= EW'($signed(r8_d[1])) - EW'($signed(r8_d[5]));
    end

    logic [SW9-1:0]       w_s13;
    logic [5:0][DOTW-1:0] w13_d;
    logic [EW-1:0]        w13_e1, w13_e2, w13_dab, w13_dac;

    cpt_delay #(.W(SW9), .DEPTH(MUL_LAT - 1)) u_dly_dots (
        .i_clk (i_clk),
        .i_d   ({r9_d, r9_e1, r9_e2, r9_dab, r9_dac}),
        .o_q   (w_s13)
    );

    assign {w13_d, w13_e1, w13_e2, w13_dab, w13_dac} = w_s13;

    // stage 14
    logic [5:0][DOTW-1:0] r14_d;
    logic signed [EW-1:0] r14_e1, r14_e2, r14_dab, r14_dac;
    logic signed [EW:0]   r14_dbc;
    logic signed [VW-1:0] r14_va, r14_vb, r14_vc;

    always_ff @(posedge i_clk) begin
        r14_d   <= w13_d;
        r14_e1  <= w13_e1;
        r14_e2  <= w13_e2;
        r14_dab <= w13_dab;
        r14_dac <= w13_dac;
        r14_dbc <= (EW+1)'($signed(w13_e1)) + (EW+1)'($signed(w13_e2));
        r14_vc  <= VW'(w_vp[0]) - VW'(w_vp[1]);
        r14_vb  <= VW'(w_vp[2]) - VW'(w_vp[3]);
        r14_va  <= VW'(w_vp[4]) - VW'(w_vp[5]);
    end

    // stage 15: region decision
    logic signed [DOTW-1:0] w_d1, w_d2, w_d3, w_d4, w_d5, w_d6;
    logic                   c_a, c_b, c_ab, c_c, c_ac, c_bc;
    t_region                n15_reg, r15_reg;
    logic signed [XW-1:0]   n15_x, r15_x;
    logic signed [DENW-1:0] n15_eden, r15_eden, r15_den;
    logic                   n15_int, r15_int;
    logic signed [VW-1:0]   r15_vb, r15_vc;

    assign w_d1 = $signed(r14_d[0]);
    assign w_d2 = $signed(r14_d[1]);
    assign w_d3 = $signed(r14_d[2]);
    assign w_d4 = $signed(r14_d[3]);
    assign w_d5 = $signed(r14_d[4]);
    assign w_d6 = $signed(r14_d[5]);

    always_comb begin
        c_a  = (w_d1 <= 0) && (w_d2 <= 0);
        c_b  = (w_d3 >= 0) && (r14_e1 <= 0);
        c_ab = (r14_vc <= 0) && (w_d1 >= 0) && (w_d3 <= 0);
        c_c  = (w_d6 >= 0) && (r14_e2 <= 0);
        c_ac = (r14_vb <= 0) && (w_d2 >= 0) && (w_d6 <= 0);
        c_bc = (r14_va <= 0) && (r14_e1 >= 0) && (r14_e2 >= 0);

        // vertex and degenerate edge cases divide zero by one
        n15_reg  = REG_IN;
        n15_x    = '0;
        n15_eden = DENW'(1);
        n15_int  = 1'b0;
        if (c_a) begin
            n15_reg = REG_A;
        end else if (c_b) begin
            n15_reg = REG_B;
        end else if (c_ab) begin
            n15_reg = REG_AB;
            if (r14_dab != 0) begin
                n15_x    = XW'(w_d1);
                n15_eden = DENW'(r14_dab);
            end
        end else if (c_c) begin
            n15_reg = REG_C;
        end else if (c_ac) begin
            n15_reg = REG_AC;
            if (r14_dac != 0) begin
                n15_x    = XW'(w_d2);
                n15_eden = DENW'(r14_dac);
            end
        end else if (c_bc) begin
            n15_reg = REG_BC;
            if (r14_dbc != 0) begin
                n15_x    = XW'(r14_e1);
                n15_eden = DENW'(r14_dbc);
            end
        end else begin
            n15_int = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r15_reg  <= n15_reg;
        r15_x    <= n15_x;
        r15_eden <= n15_eden;
        r15_int  <= n15_int;
        r15_den  <= DENW'(r14_va) + DENW'(r14_vb) + DENW'(r14_vc);
        r15_vb   <= r14_vb;
        r15_vc   <= r14_vc;
    end

    // geometry carried alongside up to the operand select
    logic [GW-1:0]      w_geo;
    logic [2:0][CW-1:0] w15_a, w15_b, w15_c;
    logic [2:0][DW-1:0] w15_ab, w15_ac, w15_cb;

    cpt_delay #(.W(GW), .DEPTH(2 * MUL_LAT + 3)) u_dly_geo (
        .i_clk (i_clk),
        .i_d   ({r2_a, r2_b, r2_c, r2_ab, r2_ac, r2_cb}),
        .o_q   (w_geo)
    );

    assign {w15_a, w15_b, w15_c, w15_ab, w15_ac, w15_cb} = w_geo;

    // stage 16: operands for the offset numerator
    t_region                n16_reg, r16_reg;
    logic signed [XW-1:0]   n16_x, n16_y, r16_x, r16_y;
    logic signed [DENW-1:0] n16_den, r16_den;
    logic [2:0][DW-1:0]     n16_d1, r16_d1, r16_d2;
    logic [2:0][CW-1:0]     n16_st, r16_st;

    always_comb begin
        if (r15_int) begin
            if (r15_den == 0) begin
                // flat triangle
                n16_reg = REG_A;
                n16_x   = '0;
                n16_y   = '0;
                n16_den = DENW'(1);
            end else begin
                n16_reg = REG_IN;
                n16_x   = r15_vb;
                n16_y   = r15_vc;
                n16_den = r15_den;
            end
        end else begin
            n16_reg = r15_reg;
            n16_x   = r15_x;
            n16_y   = '0;
            n16_den = r15_eden;
        end

        case (n16_reg) inside
            REG_AC:  n16_d1 = w15_ac;
            REG_BC:  n16_d1 = w15_cb;
            default: n16_d1 = w15_ab;
        endcase

        case (n16_reg) inside
            REG_B, REG_BC: n16_st = w15_b;
            REG_C:         n16_st = w15_c;
            default:       n16_st = w15_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r16_reg <= n16_reg;
        r16_x   <= n16_x;
        r16_y   <= n16_y;
        r16_den <= n16_den;
        r16_d1  <= n16_d1;
        r16_d2  <= w15_ac;
        r16_st  <= n16_st;
    end

    logic signed [XW+DW-1:0] w_m1 [3];
    logic signed [XW+DW-1:0] w_m2 [3];

    for (genvar k = 0; k < 3; k++) begin : g_num
        cpt_mul #(.WA(XW), .WB(DW)) u_mul1 (
            .i_clk (i_clk),
            .i_a   (r16_x),
            .i_b   (r16_d1[k]),
            .o_p   (w_m1[k])
        );
        cpt_mul #(.WA(XW), .WB(DW)) u_mul2 (
            .i_clk (i_clk),
            .i_a   (r16_y),
            .i_b   (r16_d2[k]),
            .o_p   (w_m2[k])
        );
    end

    logic [TLW-1:0]     w_tail;
    logic [DENW-1:0]    w21_den;
    logic [2:0][CW-1:0] w21_st;
    logic [2:0]         w21_reg;

    cpt_delay #(.W(TLW), .DEPTH(MUL_LAT)) u_dly_tail (
        .i_clk (i_clk),
        .i_d   ({r16_den, r16_st, r16_reg}),
        .o_q   (w_tail)
    );

    assign {w21_den, w21_st, w21_reg} = w_tail;

    // stage 22: numerators
    logic signed [NUMW-1:0] r22_num [3];
    logic signed [DENW-1:0] r22_den;
    logic [2:0][CW-1:0]     r22_st;
    logic [2:0]             r22_reg;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r22_num[k] <= NUMW'(w_m1[k]) + NUMW'(w_m2[k]);
        end
        r22_den <= $signed(w21_den);
        r22_st  <= w21_st;
        r22_reg <= w21_reg;
    end

    logic signed [CW-1:0] w_res [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        cpt_div #(.NUMW(NUMW), .DENW(DENW), .CW(CW)) u_div (
            .i_clk  (i_clk),
            .i_num  (r22_num[k]),
            .i_den  (r22_den),
            .i_base (r22_st[k]),
            .o_res  (w_res[k])
        );
    end

    logic [2:0] w_reg_out;

    cpt_delay #(.W(3), .DEPTH(DL)) u_dly_reg (
        .i_clk (i_clk),
        .i_d   (r22_reg),
        .o_q   (w_reg_out)
    );

    assign o_closest_x = w_res[0];
    assign o_closest_y = w_res[1];
    assign o_closest_z = w_res[2];
    assign o_region    = t_region'(w_reg_out);

    // every accepted item must come out as a strobed result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##OUT_LAT o_valid)
        else $error("accepted item gave no result");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |-> ##OUT_LAT !o_valid)
        else $error("result without an accepted item");

    a_vertex_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region == REG_A) |-> (o_closest_x == $past(i_vertex_a_x, OUT_LAT)))
        else $error("vertex a region gave another point");

    a_vertex_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region == REG_B) |-> (o_closest_y == $past(i_vertex_b_y, OUT_LAT)))
        else $error("vertex b region gave another point");

endmodule

FILE: tb/sv/cpt_checker.sv
// ---------------------------------------------------------------------------
// cpt_checker
// watches the item and result channels of closest_point_on_triangle, works
// out the closest point and region of each accepted item at full width and
// compares every strobed result, oldest first
// ---------------------------------------------------------------------------
module cpt_checker import cpt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_vertex_a_x,
    input  logic signed [31:0] i_vertex_a_y,
    input  logic signed [31:0] i_vertex_a_z,
    input  logic signed [31:0] i_vertex_b_x,
    input  logic signed [31:0] i_vertex_b_y,
    input  logic signed [31:0] i_vertex_b_z,
    input  logic signed [31:0] i_vertex_c_x,
    input  logic signed [31:0] i_vertex_c_y,
    input  logic signed [31:0] i_vertex_c_z,
    input  logic               o_valid,
    input  logic signed [31:0] o_closest_x,
    input  logic signed [31:0] o_closest_y,
    input  logic signed [31:0] o_closest_z,
    input  t_region            o_region,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;
    typedef wide_t vec_t [3];

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        t_region            region;
    } closest_t;

    closest_t closest_q [$];

    function automatic logic signed [31:0] saturate(input wide_t v);
        wide_t hi, lo;
        hi = 256'sd2147483647;
        lo = -256'sd2147483648;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[31:0];
    endfunction

    function automatic wide_t dot3(input vec_t u, input vec_t v);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function automatic vec_t diff3(input vec_t u, input vec_t v);
        vec_t r;
        for (int k = 0; k < 3; k++) r[k] = u[k] - v[k];
        return r;
    endfunction

    function automatic closest_t pack_point(input vec_t r, input t_region reg_code);
        closest_t c;
        c.x = saturate(r[0]);
        c.y = saturate(r[1]);
        c.z = saturate(r[2]);
        c.region = reg_code;
        return c;
    endfunction

    // start + trunc(num * dir / den), start alone on a degenerate edge
    function automatic closest_t on_edge(input vec_t s, input vec_t dir, input wide_t num,
                                         input wide_t den, input t_region reg_code);
        vec_t r;
        r = s;
        if (den != 0)
            for (int k = 0; k < 3; k++) r[k] = s[k] + (num * dir[k]) / den;
        return pack_point(r, reg_code);
    endfunction

    function automatic closest_t closest_point(input vec_t p, input vec_t a,
                                               input vec_t b, input vec_t c);
        vec_t ab, ac, ap, bp, cp, r;
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, den;
        ab = diff3(b, a);
        ac = diff3(c, a);
        ap = diff3(p, a);
        d1 = dot3(ab, ap);
        d2 = dot3(ac, ap);
        if (d1 <= 0 && d2 <= 0) return pack_point(a, REG_A);
        bp = diff3(p, b);
        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        if (d3 >= 0 && d4 <= d3) return pack_point(b, REG_B);
        vc = d1 * d4 - d3 * d2;
        if (vc <= 0 && d1 >= 0 && d3 <= 0) return on_edge(a, ab, d1, d1 - d3, REG_AB);
        cp = diff3(p, c);
        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        if (d6 >= 0 && d5 <= d6) return pack_point(c, REG_C);
        vb = d5 * d2 - d1 * d6;
        if (vb <= 0 && d2 >= 0 && d6 <= 0) return on_edge(a, ac, d2, d2 - d6, REG_AC);
        va = d3 * d6 - d5 * d4;
        e1 = d4 - d3;
        e2 = d5 - d6;
        if (va <= 0 && e1 >= 0 && e2 >= 0)
            return on_edge(b, diff3(c, b), e1, e1 + e2, REG_BC);
        den = va + vb + vc;
        // flat triangle falls back to vertex a
        if (den == 0) return pack_point(a, REG_A);
        for (int k = 0; k < 3; k++) r[k] = a[k] + (vb * ab[k] + vc * ac[k]) / den;
        return pack_point(r, REG_IN);
    endfunction

    always @(posedge i_clk) begin
        vec_t p, a, b, c;
        closest_t want;
        if (!i_rst_n) begin
            closest_q.delete();
            o_fail_count <= 0;
        end else begin
            if (start && !busy) begin
                p[0] = i_point_x;    p[1] = i_point_y;    p[2] = i_point_z;
                a[0] = i_vertex_a_x; a[1] = i_vertex_a_y; a[2] = i_vertex_a_z;
                b[0] = i_vertex_b_x; b[1] = i_vertex_b_y; b[2] = i_vertex_b_z;
                c[0] = i_vertex_c_x; c[1] = i_vertex_c_y; c[2] = i_vertex_c_z;
                closest_q.push_back(closest_point(p, a, b, c));
            end
            if (o_valid) begin
                if (closest_q.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = closest_q.pop_front();
                    if (o_closest_x !== want.x || o_closest_y !== want.y ||
                        o_closest_z !== want.z || o_region !== want.region) begin
                        if (o_closest_x !== want.x)
                            $error("closest_x expected %0d got %0d", want.x, o_closest_x);
                        if (o_closest_y !== want.y)
                            $error("closest_y expected %0d got %0d", want.y, o_closest_y);
                        if (o_closest_z !== want.z)
                            $error("closest_z expected %0d got %0d", want.z, o_closest_z);
                        if (o_region !== want.region)
                            $error("region expected %0d got %0d", want.region, o_region);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= closest_q.size();
    end

endmodule

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// stimulus for closest_point_on_triangle: directed region and corner cases,
// then random triangles under three sender idling phases; checking is done
// by cpt_checker
// ---------------------------------------------------------------------------
module tb import cpt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE = 65536;
    localparam int STALL_LIMIT = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] coords [12];
    logic               o_valid;
    logic signed [31:0] o_closest_x, o_closest_y, o_closest_z;
    t_region            o_region;
    int                 fail_count, pending;
    int                 idle_pct;
    int                 stall_cycles = 0;

    initial for (int k = 0; k < 12; k++) coords[k] = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    closest_point_on_triangle uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point_x(coords[0]), .i_point_y(coords[1]), .i_point_z(coords[2]),
        .i_vertex_a_x(coords[3]), .i_vertex_a_y(coords[4]), .i_vertex_a_z(coords[5]),
        .i_vertex_b_x(coords[6]), .i_vertex_b_y(coords[7]), .i_vertex_b_z(coords[8]),
        .i_vertex_c_x(coords[9]), .i_vertex_c_y(coords[10]), .i_vertex_c_z(coords[11]),
        .o_valid(o_valid), .o_closest_x(o_closest_x), .o_closest_y(o_closest_y),
        .o_closest_z(o_closest_z), .o_region(o_region)
    );

    cpt_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point_x(coords[0]), .i_point_y(coords[1]), .i_point_z(coords[2]),
        .i_vertex_a_x(coords[3]), .i_vertex_a_y(coords[4]), .i_vertex_a_z(coords[5]),
        .i_vertex_b_x(coords[6]), .i_vertex_b_y(coords[7]), .i_vertex_b_z(coords[8]),
        .i_vertex_c_x(coords[9]), .i_vertex_c_y(coords[10]), .i_vertex_c_z(coords[11]),
        .o_valid(o_valid), .o_closest_x(o_closest_x), .o_closest_y(o_closest_y),
        .o_closest_z(o_closest_z), .o_region(o_region),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // one query item: point, then vertices a, b, c
    task automatic send_query(input logic signed [31:0] vals [12]);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        for (int k = 0; k < 12; k++) coords[k] <= vals[k];
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_units(input int px, py, pz, ax, ay, az, bx, by, bz,
                              cx, cy, cz);
        logic signed [31:0] v [12];
        v = '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
        for (int k = 0; k < 12; k++) v[k] = v[k] * ONE;
        send_query(v);
    endtask

    function automatic logic signed [31:0] random_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return ($signed($urandom_range(2047)) - 1024) <<< 12;
            2: return $signed($urandom_range(255)) - 128;
            default: begin
                case ($urandom_range(3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 0;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic send_random();
        logic signed [31:0] v [12];
        int mode, pick, sel;
        mode = $urandom_range(9);
        mode = (mode < 2) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
        for (int k = 0; k < 12; k++) v[k] = random_coord(mode);
        pick = $urandom_range(9);
        sel = $urandom_range(2);
        // shared vertices, a point on a vertex or collinear vertices for degenerate cases
        if (pick == 0) for (int k = 0; k < 3; k++) v[6 + k] = v[3 + k];
        if (pick == 1) for (int k = 0; k < 3; k++) v[9 + k] = v[6 + k];
        if (pick == 2) for (int k = 0; k < 3; k++) v[k] = v[3 + 3 * sel + k];
        if (pick == 3) for (int k = 0; k < 3; k++) v[9 + k] = 2 * v[6 + k] - v[3 + k];
        send_query(v);
    endtask

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        logic signed [31:0] v [12];
        int end_wait;
        idle_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // each region of a right triangle in the xy plane
        send_units(-1, -1, 0,  0, 0, 0,  10, 0, 0,  0, 10, 0);
        send_units(11, -1, 2,  0, 0, 0,  10, 0, 0,  0, 10, 0);
        send_units(5, -2, 1,   0, 0, 0,  10, 0, 0,  0, 10, 0);
        send_units(-1, 11, 0,  0, 0, 0,  10, 0, 0,  0, 10, 0);
        send_units(-3, 5, -4,  0, 0, 0,  10, 0, 0,  0, 10, 0);
        send_units(6, 6, 1,    0, 0, 0,  10, 0, 0,  0, 10, 0);
        send_units(2, 3, 7,    0, 0, 0,  10, 0, 0,  0, 10, 0);
        send_units(1, 1, -5,   1, 2, 3,  -7, 4, 9,  5, -6, 2);
        // degenerate edges and flat triangles
        send_units(4, 4, 4,    2, 2, 2,  2, 2, 2,  8, 1, 0);
        send_units(4, 4, 4,    0, 0, 0,  6, 0, 0,  6, 0, 0);
        send_units(3, 5, 1,    0, 0, 0,  2, 2, 0,  4, 4, 0);
        send_units(3, 3, 3,    1, 1, 1,  1, 1, 1,  1, 1, 1);
        send_units(0, 0, 0,    0, 0, 0,  0, 0, 0,  0, 0, 0);
        // extremes of the coordinate range, then one triangle of tiny raw coordinates
        for (int k = 0; k < 12; k++) v[k] = 32'sh7fffffff;
        send_query(v);
        for (int k = 0; k < 12; k++) v[k] = 32'sh80000000;
        send_query(v);
        for (int k = 0; k < 12; k++) v[k] = (k % 2) ? 32'sh80000000 : 32'sh7fffffff;
        send_query(v);
        for (int k = 0; k < 12; k++) v[k] = (k < 3 || k > 8) ? 32'sh7fffffff : 32'sh80000000;
        send_query(v);
        v = '{0, 0, 0, 32'sh80000000, 32'sh80000000, 0, 32'sh7fffffff, 32'sh80000000, 0,
              32'sh80000000, 32'sh7fffffff, 0};
        send_query(v);
        v = '{-1, -1, -1, 1, 1, 1, -2, 3, 1, 2, -3, 1};
        send_query(v);

        idle_pct = 30;
        repeat (460) send_random();
        idle_pct = 81;
        repeat (460) send_random();
        idle_pct = 0;
        repeat (460) send_random();
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        end_wait = 3 * MUL_LAT + 7 + div_lat(32) + 10;
        repeat (end_wait) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
src/cpt_pkg.sv
src/cpt_delay.sv
src/cpt_mul.sv
src/cpt_div.sv
src/closest_point_on_triangle.sv
tb/sv/cpt_checker.sv
tb/sv/tb.sv
